// ===== rtl/rufu_pkg.sv =====
// Package for the rule engine fact update block.
// Holds sizes, mode codes and the item and result structs; no dependencies.
package rufu_pkg;

  localparam int NumFacts = 64;
  localparam int FactW    = 64;
  localparam int TokW     = 7;
  localparam int IdxW     = TokW - 1;

  localparam logic [FactW:0]   FactMaskW = ((FactW+1)'(1) << NumFacts) - (FactW+1)'(1);
  localparam logic [FactW-1:0] FactMask  = FactMaskW[FactW-1:0];

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_EXPR  = 2'd1,
    MODE_TOKEN = 2'd2,
    MODE_END   = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e             mode;
    logic [FactW-1:0]  fact_value;
    logic [FactW-1:0]  present_mask;
    logic [FactW-1:0]  absent_mask;
    logic              last_expression;
    logic [TokW-1:0]   output_token;
  } item_t;

  typedef struct packed {
    logic [FactW-1:0]  fact_bits;
    logic              action_matched;
    logic              pass_changed;
  } result_t;

endpackage

// ===== rtl/rufu_match.sv =====
// Expression test: all present literals set, all absent literals clear, not empty.
// Depends on rufu_pkg.
module rufu_match import rufu_pkg::*; (
  input  logic [FactW-1:0] facts_i,
  input  logic [FactW-1:0] present_mask_i,
  input  logic [FactW-1:0] absent_mask_i,
  output logic             hit_o
);

  logic nonempty;
  logic present_ok;
  logic absent_ok;

  assign nonempty   = |(present_mask_i | absent_mask_i);
  assign present_ok = ~|(present_mask_i & ~facts_i);
  assign absent_ok  = ~|(absent_mask_i & facts_i);
  assign hit_o      = nonempty & present_ok & absent_ok;

endmodule

// ===== rtl/rufu_state.sv =====
// Fact set and rule flags; applies one registered item per cycle while step_i is high.
// Depends on rufu_pkg and rufu_match.
module rufu_state import rufu_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  output result_t result_o
);

  logic [FactW-1:0] facts_q, facts_d;
  logic             acc_q, acc_d;
  logic             latch_q, latch_d;
  logic             fired_q, fired_d;
  logic             expr_hit;
  logic             hit;
  logic [IdxW-1:0]  idx;
  logic             idx_ok;
  logic [FactW-1:0] bit_sel;

  rufu_match u_match (
    .facts_i        (facts_q),
    .present_mask_i (item_i.present_mask),
    .absent_mask_i  (item_i.absent_mask),
    .hit_o          (expr_hit)
  );

  assign hit     = acc_q | expr_hit;
  assign idx     = item_i.output_token[TokW-1:1];
  assign idx_ok  = ({1'b0, idx} < (IdxW+1)'(NumFacts));
  assign bit_sel = FactW'(1) << idx;

  always_comb begin
    facts_d = facts_q;
    acc_d   = acc_q;
    latch_d = latch_q;
    fired_d = fired_q;
    if (step_i) begin
      unique case (item_i.mode)
        MODE_LOAD: begin
          facts_d = item_i.fact_value & FactMask;
        end
        MODE_EXPR: begin
          if (item_i.last_expression) begin
            latch_d = hit;
            fired_d = fired_q | hit;
            acc_d   = 1'b0;
          end else begin
            acc_d = hit;
          end
        end
        MODE_TOKEN: begin
          if (latch_q && idx_ok) begin
            if (item_i.output_token[0]) begin
              facts_d = facts_q | bit_sel;
            end else begin
              facts_d = facts_q & ~bit_sel;
            end
          end
        end
        MODE_END: begin
          fired_d = 1'b0;
        end
        default: begin
          facts_d = facts_q;
        end
      endcase
    end
  end

  // reported flag is the value before the end-of-pass clear
  always_comb begin
    result_o.fact_bits      = facts_d;
    result_o.action_matched = latch_d;
    result_o.pass_changed   = (item_i.mode == MODE_END) ? fired_q : fired_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      facts_q <= '0;
      acc_q   <= 1'b0;
      latch_q <= 1'b0;
      fired_q <= 1'b0;
    end else begin
      facts_q <= facts_d;
      acc_q   <= acc_d;
      latch_q <= latch_d;
      fired_q <= fired_d;
    end
  end

endmodule

// ===== rtl/rule_engine_fact_update.sv =====
// Top level of the rule engine fact update block: input register, state, result register.
// Depends on rufu_pkg and rufu_state.
//
// Each beat is a load, one rule expression, one output token or an end of pass,
// and returns exactly one result beat with the fact set and flags after it.
// An accepted beat is registered, applied to the fact set when it leaves the input
// register, and its result registered in the result register; one beat per cycle
// is sustained while the output side is ready.
// Stalls on the output hold both stages; the input takes a beat whenever its
// register is empty or moving forward.
module rule_engine_fact_update import rufu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       mode_i,
  input  logic [FactW-1:0] fact_value_i,
  input  logic [FactW-1:0] present_mask_i,
  input  logic [FactW-1:0] absent_mask_i,
  input  logic             last_expression_i,
  input  logic [TokW-1:0]  output_token_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [FactW-1:0] fact_bits_o,
  output logic             action_matched_o,
  output logic             pass_changed_o
);

  item_t   item_q;
  logic    item_vld_q;
  result_t res_q;
  logic    res_vld_q;
  result_t res_d;
  logic    out_adv;
  logic    in_fire;
  logic    step;

  assign out_adv    = !res_vld_q || out_ready_i;
  assign step       = item_vld_q && out_adv;
  assign in_ready_o = !item_vld_q || out_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  rufu_state u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_q),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      if (in_ready_o) begin
        item_vld_q <= in_valid_i;
      end
      if (out_adv) begin
        res_vld_q <= item_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.mode            <= mode_e'(mode_i);
      item_q.fact_value      <= fact_value_i;
      item_q.present_mask    <= present_mask_i;
      item_q.absent_mask     <= absent_mask_i;
      item_q.last_expression <= last_expression_i;
      item_q.output_token    <= output_token_i;
    end
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = res_vld_q;
  assign fact_bits_o      = res_q.fact_bits;
  assign action_matched_o = res_q.action_matched;
  assign pass_changed_o   = res_q.pass_changed;

endmodule
